### rtl/core/pret_pkg.sv
package pret_pkg;

  // default build values
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  // fixed field widths
  localparam int CMD_W       = 2;
  localparam int COORD_W     = 16;
  localparam int ROW_W       = 10;
  localparam int SPAN_W      = 15;
  localparam int ROW_COUNT_W = 11;
  localparam int COL_COUNT_W = 15;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 15;

  // table entry: {high, low}, both signed
  localparam int VAL_W  = 16;
  localparam int WORD_W = 2 * VAL_W;

  // running column and slope are 32-bit wrapping fixed point
  localparam int POS_W     = 32;
  localparam int DIV_STEPS = POS_W;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = ROW_COUNT_W'(1024);
  localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = COL_COUNT_W'(1024);

  localparam logic signed [VAL_W-1:0] EMPTY_LOW  = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] EMPTY_HIGH = 16'sh8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_idx_e;

endpackage

### rtl/core/pret_div.sv
module pret_div #(
  parameter int DENW = pret_pkg::COORD_BITS_DEF + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pret_pkg::POS_W-1:0] num_i,
  input  logic [DENW-1:0]            den_i,
  output logic                       done_o,
  output logic [pret_pkg::POS_W-1:0] quot_o
);

  localparam int RW   = DENW + 1;
  localparam int CNTW = $clog2(pret_pkg::DIV_STEPS + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CNTW-1:0]            cnt_q;
  logic [pret_pkg::POS_W-1:0] quo_q;
  logic [RW-1:0]              rem_q;
  logic [DENW-1:0]            md_q;
  logic                       neg_q;

  logic [RW-1:0] rem_sh;
  logic          fits;
  logic [RW-1:0] rem_nx;

  // restoring division, one quotient bit per cycle on magnitudes
  assign rem_sh = {rem_q[RW-2:0], quo_q[pret_pkg::POS_W-1]};
  assign fits   = rem_sh >= {1'b0, md_q};
  assign rem_nx = fits ? (rem_sh - {1'b0, md_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      md_q   <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(pret_pkg::DIV_STEPS);
        quo_q  <= num_i[pret_pkg::POS_W-1] ? (0 - num_i) : num_i;
        md_q   <= den_i[DENW-1] ? (DENW'(0) - den_i) : den_i;
        neg_q  <= num_i[pret_pkg::POS_W-1] ^ den_i[DENW-1];
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[pret_pkg::POS_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (0 - quo_q) : quo_q;

endmodule

### rtl/core/pret_mem.sv
module pret_mem #(
  parameter int DEPTH = pret_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(DEPTH)-1:0]    waddr_i,
  input  logic [pret_pkg::WORD_W-1:0] wdata_i,
  input  logic [$clog2(DEPTH)-1:0]    raddr_i,
  output logic [pret_pkg::WORD_W-1:0] rdata_o
);

  logic [pret_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [pret_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/polygon_row_extent_table.sv
// Reset: a clearing pass writes all MAX_ROWS table rows, one per cycle; in_ready_o
//   stays low until the pass is done. Config writes are taken at any time.
// Clear: a clearing pass over the first size rows; none when size is 0 (size = min(row_count, MAX_ROWS)).
// Edge: a radix-2 slope divider, a clip multiply and adjust, then one table
//   read-modify-write per row; an off-screen edge is taken and dropped.
// Read: the row is read from the table, then loaded into the output register once it has room.
module polygon_row_extent_table #(
  parameter int MAX_ROWS   = pret_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS  = pret_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = pret_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pret_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pret_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pret_pkg::CMD_W-1:0]      cmd_i,
  input  logic [pret_pkg::COORD_W-1:0]    x_a_i,
  input  logic [pret_pkg::COORD_W-1:0]    y_a_i,
  input  logic [pret_pkg::COORD_W-1:0]    x_b_i,
  input  logic [pret_pkg::COORD_W-1:0]    y_b_i,
  input  logic [pret_pkg::ROW_W-1:0]      row_i,

  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pret_pkg::ROW_W-1:0]      row_out_o,
  output logic [pret_pkg::SPAN_W-1:0]     span_begin_o,
  output logic [pret_pkg::SPAN_W-1:0]     span_end_o
);

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int SZW  = AW + 1;
  localparam int CW   = COORD_BITS;
  localparam int DENW = CW + 1;
  localparam int PW   = pret_pkg::POS_W;
  localparam int VW   = pret_pkg::VAL_W;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADJ,
    ST_WALK,
    ST_RESP
  } state_e;

  state_e state_q;

  logic [pret_pkg::ROW_COUNT_W-1:0] row_count_q;
  logic [pret_pkg::COL_COUNT_W-1:0] col_count_q;

  logic [SZW-1:0]         clr_idx_q;
  logic [SZW-1:0]         clr_end_q;
  logic [SZW-1:0]         row_q;
  logic [SZW-1:0]         bot_q;
  logic                   clip_q;
  logic [CW-1:0]          diff_q;
  logic [PW-1:0]          pos_q;
  logic [PW-1:0]          slope_q;
  logic [PW-1:0]          prod_q;
  logic                   wv_q;
  logic [AW-1:0]          wa_q;
  logic signed [VW-1:0]   v_q;
  logic [pret_pkg::ROW_W-1:0] rrow_q;
  logic                   rin_q;

  logic                           out_valid_q;
  logic [pret_pkg::ROW_W-1:0]     row_out_q;
  logic [pret_pkg::SPAN_W-1:0]    span_begin_q;
  logic [pret_pkg::SPAN_W-1:0]    span_end_q;

  // ---------------------------------------------------------------- edge setup
  logic [SZW-1:0]          size_w;
  logic signed [CW-1:0]    ra, ca, rb, cb;
  logic signed [CW:0]      ra_x, ca_x, rb_x, cb_x;
  logic                    a_is_top;
  logic signed [CW-1:0]    top_s, bot_s, topc_s;
  logic signed [CW:0]      d_w, den_w, cdiff_w;
  logic [PW-1:0]           num_w, pos_init_w;
  logic signed [PW-1:0]    top32, bot32, size32, tdiff32;
  logic                    off_w;
  logic                    accept;
  logic                    div_start, div_done;
  logic [PW-1:0]           div_quot;

  assign size_w = (32'(row_count_q) < 32'(MAX_ROWS)) ? SZW'(row_count_q) : SZW'(MAX_ROWS);

  assign ra = x_a_i[CW-1:0];
  assign ca = y_a_i[CW-1:0];
  assign rb = x_b_i[CW-1:0];
  assign cb = y_b_i[CW-1:0];
  assign ra_x = {ra[CW-1], ra};
  assign ca_x = {ca[CW-1], ca};
  assign rb_x = {rb[CW-1], rb};
  assign cb_x = {cb[CW-1], cb};

  assign a_is_top = ra > rb;
  assign top_s    = a_is_top ? ra : rb;
  assign bot_s    = a_is_top ? rb : ra;
  assign topc_s   = a_is_top ? ca : cb;
  assign d_w      = a_is_top ? (rb_x - ra_x) : (ra_x - rb_x);
  assign den_w    = (d_w == '0) ? DENW'(1) : d_w;   // horizontal edge divides by one
  assign cdiff_w  = a_is_top ? (cb_x - ca_x) : (ca_x - cb_x);
  assign num_w    = {{(PW-1-CW){cdiff_w[CW]}}, cdiff_w} << FRAC_BITS;
  assign pos_init_w = {{(PW-CW){topc_s[CW-1]}}, topc_s} << FRAC_BITS;

  assign top32   = {{(PW-CW){top_s[CW-1]}}, top_s};
  assign bot32   = {{(PW-CW){bot_s[CW-1]}}, bot_s};
  assign size32  = PW'(size_w);
  assign tdiff32 = top32 - size32;
  assign off_w   = (top32 < 0) || (bot32 >= size32);

  assign accept    = in_valid_i && in_ready_o;
  assign div_start = accept && (pret_pkg::cmd_e'(cmd_i) == pret_pkg::CMD_EDGE) && !off_w;

  pret_div #(
    .DENW (DENW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w),
    .den_i   (den_w),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------- walk value
  logic signed [PW-1:0] pos_sh;
  logic signed [VW-1:0] v_w;
  logic [SZW-1:0]       row_dec;

  assign pos_sh  = $signed(pos_q) >>> FRAC_BITS;
  assign v_w     = (pos_sh < PW'(pret_pkg::EMPTY_HIGH)) ? pret_pkg::EMPTY_HIGH :
                   (pos_sh > PW'(pret_pkg::EMPTY_LOW))  ? pret_pkg::EMPTY_LOW  :
                   pos_sh[VW-1:0];
  assign row_dec = row_q - 1'b1;

  // ---------------------------------------------------------------- table
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [pret_pkg::WORD_W-1:0] mem_wdata, mem_rdata;
  logic signed [VW-1:0]        old_lo, old_hi, new_lo, new_hi;
  logic [AW+pret_pkg::ROW_W-1:0] row_in_ext, rrow_ext;
  logic                        in_range_w;

  assign old_lo = mem_rdata[VW-1:0];
  assign old_hi = mem_rdata[2*VW-1:VW];
  assign new_lo = (v_q < old_lo) ? v_q : old_lo;
  assign new_hi = (v_q > old_hi) ? v_q : old_hi;

  assign row_in_ext = (AW+pret_pkg::ROW_W)'(row_i);
  assign rrow_ext   = (AW+pret_pkg::ROW_W)'(rrow_q);
  assign in_range_w = 32'(row_i) < 32'(MAX_ROWS);

  always_comb begin
    if (state_q == ST_CLR) begin
      mem_we    = clr_idx_q < clr_end_q;
      mem_waddr = clr_idx_q[AW-1:0];
      mem_wdata = {pret_pkg::EMPTY_HIGH, pret_pkg::EMPTY_LOW};
    end else begin
      mem_we    = wv_q;
      mem_waddr = wa_q;
      mem_wdata = {new_hi, new_lo};
    end
  end

  always_comb begin
    case (state_q)
      ST_WALK: mem_raddr = row_dec[AW-1:0];
      ST_RESP: mem_raddr = rrow_ext[AW-1:0];
      default: mem_raddr = row_in_ext[AW-1:0];
    endcase
  end

  pret_mem #(
    .DEPTH (MAX_ROWS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------- read-out clamp
  logic signed [VW-1:0] rd_lo, rd_hi;
  logic [pret_pkg::SPAN_W-1:0] beg_w, end_w;

  assign rd_lo = rin_q ? old_lo : pret_pkg::EMPTY_LOW;
  assign rd_hi = rin_q ? old_hi : pret_pkg::EMPTY_HIGH;

  assign beg_w = rd_lo[VW-1] ? '0 :
                 (rd_lo[pret_pkg::SPAN_W-1:0] > col_count_q) ? col_count_q :
                 rd_lo[pret_pkg::SPAN_W-1:0];
  assign end_w = rd_hi[VW-1] ? '0 :
                 (rd_hi[pret_pkg::SPAN_W-1:0] > col_count_q) ? col_count_q :
                 rd_hi[pret_pkg::SPAN_W-1:0];

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      row_count_q  <= pret_pkg::ROW_COUNT_RST;
      col_count_q  <= pret_pkg::COL_COUNT_RST;
      clr_idx_q    <= '0;
      clr_end_q    <= SZW'(MAX_ROWS);
      row_q        <= '0;
      bot_q        <= '0;
      clip_q       <= 1'b0;
      diff_q       <= '0;
      pos_q        <= '0;
      slope_q      <= '0;
      prod_q       <= '0;
      wv_q         <= 1'b0;
      wa_q         <= '0;
      v_q          <= '0;
      rrow_q       <= '0;
      rin_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      row_out_q    <= '0;
      span_begin_q <= '0;
      span_end_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (pret_pkg::cfg_idx_e'(cfg_index_i))
          pret_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data_i[pret_pkg::ROW_COUNT_W-1:0];
          pret_pkg::CFG_COL_COUNT: col_count_q <= cfg_data_i[pret_pkg::COL_COUNT_W-1:0];
          default: ;
        endcase
      end

      if ((state_q == ST_RESP) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      wv_q <= (state_q == ST_WALK) && (row_q > bot_q);

      case (state_q)
        ST_CLR: begin
          if (clr_idx_q < clr_end_q) begin
            clr_idx_q <= clr_idx_q + 1'b1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            case (pret_pkg::cmd_e'(cmd_i))
              pret_pkg::CMD_CLEAR: begin
                if (size_w != '0) begin
                  clr_idx_q <= '0;
                  clr_end_q <= size_w;
                  state_q   <= ST_CLR;
                end
              end
              pret_pkg::CMD_EDGE: begin
                if (!off_w) begin
                  clip_q  <= tdiff32 >= 0;
                  diff_q  <= tdiff32[CW-1:0];
                  row_q   <= (tdiff32 >= 0) ? size_w : top32[SZW-1:0];
                  bot_q   <= (bot32 < 0) ? '0 : bot32[SZW-1:0];
                  pos_q   <= pos_init_w;
                  state_q <= ST_DIV;
                end
              end
              pret_pkg::CMD_READ: begin
                rrow_q  <= row_i;
                rin_q   <= in_range_w;
                state_q <= ST_RESP;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            slope_q <= div_quot;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= slope_q * {{(PW-CW){1'b0}}, diff_q};
          state_q <= ST_ADJ;
        end
        ST_ADJ: begin
          // top clipped to the table: advance the column over the skipped rows
          if (clip_q) begin
            pos_q <= pos_q - prod_q;
          end
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          // read row r-1 now, fold and write it back next cycle
          if (row_q > bot_q) begin
            row_q <= row_dec;
            wa_q  <= row_dec[AW-1:0];
            v_q   <= v_w;
            pos_q <= pos_q - slope_q;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            row_out_q    <= rrow_q;
            span_begin_q <= beg_w;
            span_end_q   <= end_w;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = state_q == ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign row_out_o    = row_out_q;
  assign span_begin_o = span_begin_q;
  assign span_end_o   = span_end_q;

  // ---------------------------------------------------------------- checks
  a_idle_no_pending_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !wv_q)
    else $error("write-back still pending while taking a new item");

  a_clear_excludes_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !wv_q)
    else $error("clear sweep and edge write-back overlap");

  a_walk_above_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (row_q >= bot_q))
    else $error("edge walk passed its bottom row");

  a_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> (32'(wa_q) < 32'(MAX_ROWS)))
    else $error("edge write beyond table");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("slope finished outside the divide step");

endmodule
